// ===== hw/rtl/tpp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpp_pkg: shared types and constants for the transfer packet parser
// Result beat layout, push strobes, status and item codes, packet constants.
// ----------------------------------------------------------------------------
package tpp_pkg;

  // output queue depth; must leave room for two beats per input byte
  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [7:0] PKT_TYPE_DATA  = 8'h02;
  localparam logic [7:0] TAG_FILE_SIZE  = 8'h00;
  localparam logic [7:0] TAG_FILE_NAME  = 8'h01;
  localparam logic [7:0] SIZE_MAX_BYTES = 8'd8;
  localparam logic [8:0] NAME_CAP_RESET = 9'd256;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BAD_NAME  = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [7:0]  packet_type;
    logic [2:0]  status;
    logic [63:0] file_size;
    logic [7:0]  name_length;
    logic [7:0]  sequence_res;
    logic [15:0] payload_length;
    logic        last_of_run;
  } res_t;

  // beats produced by one accepted byte: forwarded byte first, then summary
  typedef struct packed {
    logic fwd;
    logic sum;
  } push_t;

endpackage

// ===== hw/rtl/transfer_packet_parser.sv =====
// ----------------------------------------------------------------------------
// transfer_packet_parser: streaming TLV transfer packet parser
// Parses data and control packets byte by byte and emits forwarded bytes
// and a per-packet summary beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one packet byte per beat, in_end_of_packet on the
//   last byte. Output channel (out_*): payload bytes, file name bytes and one
//   summary beat per packet (out_last_of_run high, status in out_status).
//   cfg_wr_en / cfg_wr_data load name_capacity; write only while idle.
// Result beats are formed from the accepted byte and registered into the output queue.
// Throughput: one input beat per cycle. A byte yields at most two beats (a
//   forwarded byte plus the summary), so the output side sets the pace: the
//   queue of OutDepth beats must have two free slots before a byte is taken.
// Stall: out_stall holds the head beat; once fewer than two queue slots are
//   free, in_stall rises and input stops until space frees up. Nothing is
//   dropped.
// Reset: synchronous, active low; parser awaits a packet's first byte,
//   the queue is empty and name_capacity returns to 256.
// ----------------------------------------------------------------------------
module transfer_packet_parser import tpp_pkg::*; #(
  parameter int unsigned OutDepth = OUTQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_packet,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_out_byte,
  output logic [7:0]  out_packet_type,
  output logic [2:0]  out_status,
  output logic [63:0] out_file_size,
  output logic [7:0]  out_name_length,
  output logic [7:0]  out_sequence_res,
  output logic [15:0] out_payload_length,
  output logic        out_last_of_run,
  // config
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  logic [8:0] name_capacity_r;
  logic       accept;
  logic       pop;
  logic       room2;
  res_t       fwd_item;
  res_t       sum_item;
  res_t       head;
  push_t      push;

  // name length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_capacity_r <= NAME_CAP_RESET;
    end else if (cfg_wr_en) begin
      name_capacity_r <= cfg_wr_data;
    end
  end

  // take a byte only when the queue can absorb its worst case of two beats
  assign in_stall = !room2;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  tpp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .byte_value    (in_byte_value),
    .end_of_packet (in_end_of_packet),
    .name_capacity (name_capacity_r),
    .fwd_item      (fwd_item),
    .sum_item      (sum_item),
    .push          (push)
  );

  tpp_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fwd_item  (fwd_item),
    .sum_item  (sum_item),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_item_kind      = head.item_kind;
  assign out_out_byte       = head.out_byte;
  assign out_packet_type    = head.packet_type;
  assign out_status         = head.status;
  assign out_file_size      = head.file_size;
  assign out_name_length    = head.name_length;
  assign out_sequence_res   = head.sequence_res;
  assign out_payload_length = head.payload_length;
  assign out_last_of_run    = head.last_of_run;

endmodule

// ===== hw/rtl/tpp_parse.sv =====
// ----------------------------------------------------------------------------
// tpp_parse: per-byte packet parse state
// Updates the parse state on each accepted byte and forms the forwarded
// byte beat and the end-of-packet summary beat.
// ----------------------------------------------------------------------------
module tpp_parse import tpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       end_of_packet,
  input  logic [8:0] name_capacity,
  output res_t       fwd_item,
  output res_t       sum_item,
  output push_t      push
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_TAG,
    PH_LEN,
    PH_VALUE,
    PH_DATA_HDR,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;      // data header byte index
  logic [7:0]  tag_r, tag_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [63:0] size_acc_r, size_acc_nxt;
  logic        size_seen_r, size_seen_nxt;
  logic        name_seen_r, name_seen_nxt;
  logic [2:0]  status_r, status_nxt;        // first error, latched
  logic [2:0]  vbad_r, vbad_nxt;            // pending bad-length code
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [15:0] plen_r, plen_nxt;

  logic        fwd_emit;
  logic        fin;
  logic        is_data;
  logic [2:0]  st;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    tag_nxt       = tag_r;
    remain_nxt    = remain_r;
    size_acc_nxt  = size_acc_r;
    size_seen_nxt = size_seen_r;
    name_seen_nxt = name_seen_r;
    status_nxt    = status_r;
    vbad_nxt      = vbad_r;
    type_nxt      = type_r;
    seq_nxt       = seq_r;
    name_len_nxt  = name_len_r;
    plen_nxt      = plen_r;
    fwd_emit      = 1'b0;
    fin           = 1'b0;
    is_data       = 1'b0;
    st            = ST_OK;

    fwd_item              = '0;
    fwd_item.out_byte     = byte_value;
    fwd_item.packet_type  = type_r;
    fwd_item.item_kind    = KIND_PAYLOAD;

    case (phase_r)
      PH_FIRST: begin
        type_nxt    = byte_value;
        hdr_cnt_nxt = 2'd0;
        phase_nxt   = (byte_value == PKT_TYPE_DATA) ? PH_DATA_HDR : PH_TAG;
      end
      PH_TAG: begin
        tag_nxt   = byte_value;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        remain_nxt = {8'h00, byte_value};
        vbad_nxt   = ST_OK;
        if (tag_r == TAG_FILE_SIZE) begin
          if (byte_value == 8'h00 || byte_value > SIZE_MAX_BYTES) begin
            vbad_nxt = ST_BAD_SIZE;
          end else begin
            size_acc_nxt = '0;
          end
        end else if (tag_r == TAG_FILE_NAME) begin
          if (byte_value == 8'h00 || {1'b0, byte_value} >= name_capacity) begin
            vbad_nxt = ST_BAD_NAME;
          end else begin
            name_len_nxt = byte_value;
          end
        end
        if (byte_value == 8'h00) begin
          fin = 1'b1;
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (vbad_r == ST_OK) begin
          if (tag_r == TAG_FILE_SIZE) begin
            size_acc_nxt = {size_acc_r[55:0], byte_value};
          end else if (tag_r == TAG_FILE_NAME) begin
            fwd_emit           = 1'b1;
            fwd_item.item_kind = KIND_NAME;
          end
        end
        remain_nxt = remain_r - 16'd1;
        if (remain_nxt == 16'd0) begin
          fin = 1'b1;
        end
      end
      PH_DATA_HDR: begin
        hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        case (hdr_cnt_r)
          2'd0: seq_nxt = byte_value;
          2'd1: plen_nxt = {8'h00, byte_value};
          default: begin
            plen_nxt   = {byte_value, plen_r[7:0]};
            remain_nxt = plen_nxt;
            phase_nxt  = (plen_nxt != 16'd0) ? PH_PAYLOAD : PH_SKIP;
          end
        endcase
      end
      PH_PAYLOAD: begin
        fwd_emit   = 1'b1;
        remain_nxt = remain_r - 16'd1;
        if (remain_nxt == 16'd0) begin
          phase_nxt = PH_SKIP;
        end
      end
      default: ;
    endcase

    // value complete: latch a pending bad length, else mark the tag seen
    if (fin) begin
      if (vbad_nxt != ST_OK) begin
        status_nxt = vbad_nxt;
        phase_nxt  = PH_SKIP;
      end else begin
        if (tag_r == TAG_FILE_SIZE) begin
          size_seen_nxt = 1'b1;
        end else if (tag_r == TAG_FILE_NAME) begin
          name_seen_nxt = 1'b1;
        end
        phase_nxt = PH_TAG;
      end
    end

    // summary beat, built from the post-update state
    is_data = (type_nxt == PKT_TYPE_DATA);
    st      = status_nxt;
    if (st == ST_OK) begin
      if (phase_nxt == PH_VALUE || phase_nxt == PH_DATA_HDR ||
          phase_nxt == PH_PAYLOAD) begin
        st = ST_TRUNC;
      end else if (!is_data && (!size_seen_nxt || !name_seen_nxt)) begin
        st = ST_MISSING;
      end
    end
    sum_item             = '0;
    sum_item.item_kind   = KIND_SUMMARY;
    sum_item.packet_type = type_nxt;
    sum_item.status      = st;
    sum_item.last_of_run = 1'b1;
    if (!is_data && st == ST_OK) begin
      sum_item.file_size   = size_acc_nxt;
      sum_item.name_length = name_len_nxt;
    end
    if (is_data) begin
      sum_item.sequence_res   = seq_nxt;
      sum_item.payload_length = (phase_nxt == PH_DATA_HDR) ? 16'd0 : plen_nxt;
    end

    // packet done: back to a clean slate
    if (end_of_packet) begin
      phase_nxt     = PH_FIRST;
      hdr_cnt_nxt   = 2'd0;
      tag_nxt       = '0;
      remain_nxt    = '0;
      size_acc_nxt  = '0;
      size_seen_nxt = 1'b0;
      name_seen_nxt = 1'b0;
      status_nxt    = ST_OK;
      vbad_nxt      = ST_OK;
      type_nxt      = '0;
      seq_nxt       = '0;
      name_len_nxt  = '0;
      plen_nxt      = '0;
    end
  end

  assign push.fwd = accept & fwd_emit;
  assign push.sum = accept & end_of_packet;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      hdr_cnt_r   <= 2'd0;
      tag_r       <= '0;
      remain_r    <= '0;
      size_acc_r  <= '0;
      size_seen_r <= 1'b0;
      name_seen_r <= 1'b0;
      status_r    <= ST_OK;
      vbad_r      <= ST_OK;
      type_r      <= '0;
      seq_r       <= '0;
      name_len_r  <= '0;
      plen_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      tag_r       <= tag_nxt;
      remain_r    <= remain_nxt;
      size_acc_r  <= size_acc_nxt;
      size_seen_r <= size_seen_nxt;
      name_seen_r <= name_seen_nxt;
      status_r    <= status_nxt;
      vbad_r      <= vbad_nxt;
      type_r      <= type_nxt;
      seq_r       <= seq_nxt;
      name_len_r  <= name_len_nxt;
      plen_r      <= plen_nxt;
    end
  end

endmodule

// ===== hw/rtl/tpp_outq.sv =====
// ----------------------------------------------------------------------------
// tpp_outq: result beat queue
// Small register queue taking up to two beats per cycle and giving one when popped.
// ----------------------------------------------------------------------------
module tpp_outq import tpp_pkg::*; #(
  parameter int unsigned Depth = OUTQ_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  res_t  fwd_item,
  input  res_t  sum_item,
  input  logic  pop,
  output res_t  head,
  output logic  not_empty,
  output logic  room2
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);
  assign wr_ptr_nxt = (push.fwd && push.sum) ? ptr_inc(wr_ptr_p1) :
                      (push.fwd || push.sum) ? wr_ptr_p1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + CntW'(push.fwd) + CntW'(push.sum) - CntW'(pop);

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CntW'(Depth - 2));

  always_ff @(posedge clk) begin
    if (push.fwd) begin
      mem[wr_ptr_r] <= fwd_item;
    end
    if (push.sum) begin
      mem[push.fwd ? wr_ptr_p1 : wr_ptr_r] <= sum_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/tpp_checker.sv =====
// ----------------------------------------------------------------------------
// tpp_checker: port-level checks for the transfer packet parser
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module tpp_checker import tpp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_packet,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_item_kind,
  input logic [7:0]  out_out_byte,
  input logic [2:0]  out_status,
  input logic        out_last_of_run
);

  // an empty output side never back-pressures the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a packet end always yields a beat on the next cycle
  a_eop_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_packet) |=> out_valid)
    else $error("no result after end of packet");

  // only summaries close a run; forwarded bytes carry ok status
  a_summary_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_last_of_run == (out_item_kind == KIND_SUMMARY)) &&
                   (out_item_kind == KIND_SUMMARY || out_status == ST_OK)))
    else $error("summary marking inconsistent");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_item_kind) && $stable(out_out_byte)))
    else $error("stalled result beat changed");

endmodule

bind transfer_packet_parser tpp_checker u_tpp_checker (.*);

// ===== bench/transfer_packet_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_packet_parser_tb: self-checking bench for the packet parser
// Feeds data and control packets byte by byte, predicts every result beat
// (forwarded payload and name bytes, per-packet summaries) and compares each
// beat field by field. Covers directed corner cases, name capacity settings,
// a long output hold-off and randomized traffic with idle and stall patterns.
// ----------------------------------------------------------------------------
module transfer_packet_parser_tb;
  import tpp_pkg::*;

  // byte budget of the random part, split over its phases
  localparam int RANDOM_BYTES  = 160;
  // long receiver hold-off; must outlast a full output queue by far
  localparam int HOLD_CYCLES   = 300;
  // spare cycles after the expected beats are in, before touching config
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;

  typedef logic [7:0] byte_q_t[$];

  // parser position inside a packet
  typedef enum logic [2:0] {
    SEEK_TYPE, READ_TAG, READ_LEN, READ_VALUE, READ_HEADER, READ_PAYLOAD, DISCARD
  } parse_phase_t;

  // receiver back-pressure styles
  typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_item_kind;
  logic [7:0]  out_out_byte;
  logic [7:0]  out_packet_type;
  logic [2:0]  out_status;
  logic [63:0] out_file_size;
  logic [7:0]  out_name_length;
  logic [7:0]  out_sequence_res;
  logic [15:0] out_payload_length;
  logic        out_last_of_run;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = 9'd0;

  // bench-side copy of the parser state
  parse_phase_t cur_phase;
  logic [15:0]  pkt_bytes;
  logic [7:0]   tag_byte;
  logic [15:0]  bytes_left;
  logic [63:0]  size_acc;
  logic         got_size;
  logic         got_name;
  logic [2:0]   first_error;
  logic [2:0]   value_error;   // bad-length code held until the value is complete
  logic [7:0]   pkt_type;
  logic [7:0]   pkt_seq;
  logic [7:0]   name_len;
  logic [15:0]  pay_len;
  logic [8:0]   name_cap;

  res_t expected_beats[$];
  int   fail_count = 0;
  int   bytes_accepted = 0;

  // sender burst/gap control
  int       burst_left = 0;
  bit       tx_gaps = 1'b1;
  // receiver stall control
  rx_mode_t rx_mode = RX_RANDOM;
  bit       hold_request = 1'b0;
  int       hold_left = 0;
  int       run_left = 0;
  logic     run_level = 1'b0;

  transfer_packet_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_end_of_packet  (in_end_of_packet),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_out_byte      (out_out_byte),
    .out_packet_type   (out_packet_type),
    .out_status        (out_status),
    .out_file_size     (out_file_size),
    .out_name_length   (out_name_length),
    .out_sequence_res  (out_sequence_res),
    .out_payload_length(out_payload_length),
    .out_last_of_run   (out_last_of_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void clear_packet_state();
    cur_phase   = SEEK_TYPE;
    pkt_bytes   = '0;
    tag_byte    = '0;
    bytes_left  = '0;
    size_acc    = '0;
    got_size    = 1'b0;
    got_name    = 1'b0;
    first_error = ST_OK;
    value_error = ST_OK;
    pkt_type    = '0;
    pkt_seq     = '0;
    name_len    = '0;
    pay_len     = '0;
  endfunction

  // value fully read: latch a pending bad length, else mark the field present
  function automatic void value_done();
    if (value_error != ST_OK) begin
      first_error = value_error;
      cur_phase   = DISCARD;
    end else begin
      if (tag_byte == TAG_FILE_SIZE) got_size = 1'b1;
      else if (tag_byte == TAG_FILE_NAME) got_name = 1'b1;
      cur_phase = READ_TAG;
    end
  endfunction

  // forwarded-byte beat; the summary starts from one too
  function automatic res_t forwarded_beat(logic [1:0] kind, logic [7:0] b);
    res_t r;
    r = '0;
    r.item_kind   = kind;
    r.out_byte    = b;
    r.packet_type = pkt_type;
    return r;
  endfunction

  // advance the parser by one accepted byte, queueing the beats it causes
  function automatic void predict_parse(logic [7:0] b, logic eop);
    res_t  r;
    logic  is_data;
    logic [2:0] st;
    if (pkt_bytes != 16'hFFFF) pkt_bytes++;
    case (cur_phase)
      SEEK_TYPE: begin
        pkt_type  = b;
        cur_phase = (b == PKT_TYPE_DATA) ? READ_HEADER : READ_TAG;
      end
      READ_TAG: begin
        tag_byte  = b;
        cur_phase = READ_LEN;
      end
      READ_LEN: begin
        bytes_left  = {8'h00, b};
        value_error = ST_OK;
        if (tag_byte == TAG_FILE_SIZE) begin
          if (b == 8'd0 || b > SIZE_MAX_BYTES) value_error = ST_BAD_SIZE;
          else size_acc = '0;
        end else if (tag_byte == TAG_FILE_NAME) begin
          if (b == 8'd0 || {1'b0, b} >= name_cap) value_error = ST_BAD_NAME;
          else name_len = b;
        end
        if (b == 8'd0) value_done();
        else cur_phase = READ_VALUE;
      end
      READ_VALUE: begin
        // bytes of a rejected value are dropped silently
        if (value_error == ST_OK) begin
          if (tag_byte == TAG_FILE_SIZE) size_acc = {size_acc[55:0], b};
          else if (tag_byte == TAG_FILE_NAME)
            expected_beats.push_back(forwarded_beat(KIND_NAME, b));
        end
        bytes_left--;
        if (bytes_left == 16'd0) value_done();
      end
      READ_HEADER: begin
        // sequence, then length low byte, then length high byte
        if (pkt_bytes == 16'd2) begin
          pkt_seq = b;
        end else if (pkt_bytes == 16'd3) begin
          pay_len = {8'h00, b};
        end else begin
          pay_len[15:8] = b;
          bytes_left    = pay_len;
          cur_phase     = (bytes_left != 16'd0) ? READ_PAYLOAD : DISCARD;
        end
      end
      READ_PAYLOAD: begin
        expected_beats.push_back(forwarded_beat(KIND_PAYLOAD, b));
        bytes_left--;
        if (bytes_left == 16'd0) cur_phase = DISCARD;
      end
      default: ;
    endcase

    if (eop) begin
      is_data = (pkt_type == PKT_TYPE_DATA);
      st      = first_error;
      if (st == ST_OK) begin
        if (cur_phase == READ_VALUE || cur_phase == READ_HEADER ||
            cur_phase == READ_PAYLOAD)
          st = ST_TRUNC;
        else if (!is_data && (!got_size || !got_name))
          st = ST_MISSING;
      end
      r = forwarded_beat(KIND_SUMMARY, 8'h00);
      r.status = st;
      if (!is_data && st == ST_OK) begin
        r.file_size   = size_acc;
        r.name_length = name_len;
      end
      if (is_data) begin
        r.sequence_res   = pkt_seq;
        // length counts only once both bytes are in
        r.payload_length = (cur_phase == READ_HEADER) ? 16'd0 : pay_len;
      end
      r.last_of_run = 1'b1;
      expected_beats.push_back(r);
      clear_packet_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every accepted beat against the oldest expectation
  // --------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected (kind %0d)", out_item_kind);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("item_kind", want.item_kind, out_item_kind);
        compare_field("out_byte", want.out_byte, out_out_byte);
        compare_field("packet_type", want.packet_type, out_packet_type);
        compare_field("status", want.status, out_status);
        compare_field("file_size", want.file_size, out_file_size);
        compare_field("name_length", want.name_length, out_name_length);
        compare_field("sequence_res", want.sequence_res, out_sequence_res);
        compare_field("payload_length", want.payload_length, out_payload_length);
        compare_field("last_of_run", want.last_of_run, out_last_of_run);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : receiver
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          // alternating runs of stall and flow
          if (run_left == 0) begin
            run_level = ~run_level;
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
          out_stall <= run_level;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender and packet builders
  // --------------------------------------------------------------------------

  // one beat; called at a rising edge, returns at the edge that accepted it
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_byte_value    <= value;
    in_end_of_packet <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_parse(value, last);
    bytes_accepted++;
  endtask

  task automatic send_packet(input byte_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // wait for all expected beats, then let the pipe settle
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
      fail_count++;
      expected_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_name_capacity(input logic [8:0] cap);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    name_cap   = cap;
  endtask

  function automatic void cut_to(ref byte_q_t p, input int n);
    while (p.size() > n) void'(p.pop_back());
  endfunction

  // tag, length, then count value bytes (random unless fill is given)
  function automatic void add_entry(ref byte_q_t p, input logic [7:0] tag,
                                    input logic [7:0] len, input int count,
                                    input int fill = -1);
    p.push_back(tag);
    p.push_back(len);
    repeat (count) p.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endfunction

  function automatic byte_q_t data_packet(logic [7:0] seq, logic [15:0] len, int n_payload);
    byte_q_t p;
    p.push_back(PKT_TYPE_DATA);
    p.push_back(seq);
    p.push_back(len[7:0]);
    p.push_back(len[15:8]);
    repeat (n_payload) p.push_back(8'($urandom_range(0, 255)));
    return p;
  endfunction

  function automatic logic [7:0] control_type();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255)); while (t == PKT_TYPE_DATA);
    return t;
  endfunction

  // name length that the current capacity accepts, mostly short
  function automatic logic [7:0] name_length_pick();
    int top;
    if (name_cap < 9'd2) return 8'd1;
    top = int'(name_cap) - 1;
    if (top > 255) top = 255;
    if ($urandom_range(0, 19) != 0 && top > 16) top = 16;
    return 8'($urandom_range(1, top));
  endfunction

  // control packet with a one-byte size and a name of the given length
  function automatic byte_q_t name_packet(logic [7:0] len);
    byte_q_t p;
    p.push_back(control_type());
    add_entry(p, TAG_FILE_SIZE, 8'd1, 1);
    add_entry(p, TAG_FILE_NAME, len, len);
    return p;
  endfunction

  function automatic byte_q_t control_packet(bit well_formed);
    byte_q_t p;
    int n_ent, pick;
    logic [7:0] len;
    bit has_size, has_name;
    has_size = 1'b0;
    has_name = 1'b0;
    p.push_back(control_type());
    n_ent = $urandom_range(well_formed ? 0 : 1, 4);
    for (int i = 0; i < n_ent; i++) begin
      pick = $urandom_range(0, 2);
      if (!well_formed) begin
        len = 8'($urandom_range(0, 12));
        add_entry(p, (pick == 2) ? 8'($urandom_range(2, 255)) : 8'(pick), len, len);
      end else if (pick == 0) begin
        len = 8'($urandom_range(1, 8));
        add_entry(p, TAG_FILE_SIZE, len, len);
        has_size = 1'b1;
      end else if (pick == 1) begin
        len = name_length_pick();
        add_entry(p, TAG_FILE_NAME, len, len);
        has_name = 1'b1;
      end else begin
        len = 8'($urandom_range(0, 5));
        add_entry(p, 8'($urandom_range(2, 255)), len, len);
      end
    end
    if (well_formed) begin
      if (!has_size) begin
        len = 8'($urandom_range(1, 8));
        add_entry(p, TAG_FILE_SIZE, len, len);
      end
      if (!has_name) begin
        len = name_length_pick();
        add_entry(p, TAG_FILE_NAME, len, len);
      end
    end else if ($urandom_range(0, 3) == 0) begin
      p.push_back(8'($urandom_range(0, 255)));   // stray tag byte at the end
    end
    return p;
  endfunction

  // mostly well-formed packets; the rest broken, truncated or plain noise
  function automatic byte_q_t random_packet();
    byte_q_t p;
    int pick, sel, n;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      p = control_packet(1'b1);
    end else if (pick < 70) begin
      sel = $urandom_range(0, 9);
      len = (sel == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 12));
      n   = int'(len);
      if (sel == 0) n = $urandom_range(0, 6);
      else if (sel == 1) n += $urandom_range(1, 4);
      else if (sel == 2 && len != 0) n = $urandom_range(0, int'(len) - 1);
      p = data_packet(8'($urandom_range(0, 255)), len, n);
      if (sel == 3) cut_to(p, $urandom_range(1, 3));
    end else if (pick < 85) begin
      p = control_packet(1'b0);
      if (p.size() > 1 && $urandom_range(0, 1) == 1)
        cut_to(p, $urandom_range(1, p.size() - 1));
    end else begin
      repeat ($urandom_range(1, 10)) p.push_back(8'($urandom_range(0, 255)));
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_data_packets();
    byte_q_t p;
    send_packet(data_packet(8'h00, 16'd3, 3));        // exact payload
    send_packet(data_packet(8'hFF, 16'd0, 2));        // zero length, extras dropped
    send_packet(data_packet(8'hA5, 16'd2, 5));        // bytes past length ignored
    send_packet(data_packet(8'h3C, 16'hFFFF, 2));     // ends early, max length
    send_packet(data_packet(8'h5A, 16'h0100, 0));     // ends right after header
    // packets that stop inside the data header
    for (int k = 1; k <= 3; k++) begin
      p = data_packet(8'h81, 16'h1234, 0);
      cut_to(p, k);
      send_packet(p);
    end
    drain();
  endtask

  task automatic test_control_packets();
    byte_q_t p;
    // largest size value plus a short name
    p.delete();
    p.push_back(8'h04);
    add_entry(p, TAG_FILE_SIZE, 8'd8, 8, 8'hFF);
    add_entry(p, TAG_FILE_NAME, 8'd3, 3);
    send_packet(p);
    // unknown tag skipped, single-byte size
    p.delete();
    p.push_back(8'hFF);
    add_entry(p, TAG_FILE_NAME, 8'd1, 1);
    add_entry(p, 8'h7E, 8'd2, 2);
    add_entry(p, TAG_FILE_SIZE, 8'd1, 1, 8'h80);
    send_packet(p);
    // repeated tags: last size and last name count, both names forwarded
    p.delete();
    p.push_back(8'h00);
    add_entry(p, TAG_FILE_SIZE, 8'd2, 2);
    add_entry(p, TAG_FILE_NAME, 8'd2, 2);
    add_entry(p, TAG_FILE_SIZE, 8'd3, 3);
    add_entry(p, TAG_FILE_NAME, 8'd1, 1);
    send_packet(p);
    // name missing
    p.delete();
    p.push_back(8'h01);
    add_entry(p, TAG_FILE_SIZE, 8'd1, 1);
    send_packet(p);
    // size missing, with an empty unknown entry
    p.delete();
    p.push_back(8'h10);
    add_entry(p, 8'h33, 8'd0, 0);
    add_entry(p, TAG_FILE_NAME, 8'd2, 2);
    send_packet(p);
    // lone tag byte at the end is harmless
    p.delete();
    p.push_back(8'h03);
    add_entry(p, TAG_FILE_SIZE, 8'd1, 1);
    add_entry(p, TAG_FILE_NAME, 8'd1, 1);
    p.push_back(TAG_FILE_NAME);
    send_packet(p);
    // size length zero: error latched, rest skipped
    p.delete();
    p.push_back(8'h20);
    add_entry(p, TAG_FILE_SIZE, 8'd0, 0);
    add_entry(p, TAG_FILE_NAME, 8'd2, 2);
    send_packet(p);
    // size length nine
    p.delete();
    p.push_back(8'h21);
    add_entry(p, TAG_FILE_SIZE, 8'd9, 9);
    send_packet(p);
    // name length zero
    p.delete();
    p.push_back(8'h22);
    add_entry(p, TAG_FILE_SIZE, 8'd1, 1);
    add_entry(p, TAG_FILE_NAME, 8'd0, 0);
    send_packet(p);
    // ends inside a name: bytes so far still forwarded
    p.delete();
    p.push_back(8'h23);
    add_entry(p, TAG_FILE_NAME, 8'd5, 2);
    send_packet(p);
    // bad size length but the packet ends first: truncated wins
    p.delete();
    p.push_back(8'h24);
    add_entry(p, TAG_FILE_SIZE, 8'd9, 3);
    send_packet(p);
    // ends right after a length byte
    p.delete();
    p.push_back(8'h25);
    add_entry(p, TAG_FILE_SIZE, 8'd4, 0);
    send_packet(p);
    // type byte only
    p.delete();
    p.push_back(8'h80);
    send_packet(p);
    drain();
  endtask

  task automatic test_name_capacity();
    write_name_capacity(9'd0);              // rejects every name
    send_packet(name_packet(8'd1));
    write_name_capacity(9'd1);
    send_packet(name_packet(8'd1));
    write_name_capacity(9'd5);              // boundary: 4 passes, 5 fails
    send_packet(name_packet(8'd4));
    send_packet(name_packet(8'd5));
    write_name_capacity(9'd511);            // above 256 accepts any length
    send_packet(name_packet(8'd255));
    write_name_capacity(NAME_CAP_RESET);
    send_packet(name_packet(8'd255));
    drain();
  endtask

  // receiver holds off while the sender keeps going: queue fills, input stalls
  task automatic test_backpressure();
    rx_mode      = RX_FREE;
    tx_gaps      = 1'b0;
    hold_request = 1'b1;
    repeat (10) send_packet(data_packet(8'($urandom_range(0, 255)), 16'd8, 8));
    drain();
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    logic [8:0] cap;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       cap = NAME_CAP_RESET;
        1:       cap = 9'd2;
        2:       cap = 9'($urandom_range(3, 40));
        default: cap = 9'd300;
      endcase
      write_name_capacity(cap);
      rx_mode = rx_mode_t'(ph % 3);
      tx_gaps = (ph != 1);
      target  = bytes_accepted + RANDOM_BYTES / 4;
      while (bytes_accepted < target) send_packet(random_packet());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence and verdict
  // --------------------------------------------------------------------------

  initial begin
    name_cap = NAME_CAP_RESET;
    clear_packet_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_data_packets();
    test_control_packets();
    test_name_capacity();
    test_backpressure();
    test_random_traffic();

    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tpp_pkg.sv
hw/rtl/tpp_parse.sv
hw/rtl/tpp_outq.sv
hw/rtl/transfer_packet_parser.sv
hw/rtl/tpp_checker.sv
bench/transfer_packet_parser_tb.sv
